### rtl/zcp_pkg.sv
// Shared types, register indexes and constants for the zero-cross pulse generator.
package zcp_pkg;

    localparam int WIDTH_BITS      = 20;
    localparam int PULSE_BITS      = 16;
    localparam int PERIOD_CFG_BITS = 21;
    localparam int CFG_DATA_BITS   = 21;
    localparam int CFG_INDEX_BITS  = 3;

    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};

    // Register reset values
    localparam logic [PERIOD_CFG_BITS-1:0] RST_WRAP_PERIOD = 21'd100000;
    localparam logic [WIDTH_BITS-1:0]      RST_MIN_WIDTH   = 20'd10500;
    localparam logic [WIDTH_BITS-1:0]      RST_MAX_WIDTH   = 20'd19500;
    localparam logic [WIDTH_BITS-1:0]      RST_LEAD        = 20'd5000;
    localparam logic [PULSE_BITS-1:0]      RST_PULSE_LEN   = 16'd1000;
    localparam logic [WIDTH_BITS-1:0]      RST_REPEAT      = 20'd10000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WRAP_PERIOD = 3'd0,
        REG_MIN_WIDTH   = 3'd1,
        REG_MAX_WIDTH   = 3'd2,
        REG_LEAD        = 3'd3,
        REG_PULSE_LEN   = 3'd4,
        REG_REPEAT      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [PERIOD_CFG_BITS-1:0] wrap_period_us;
        logic [WIDTH_BITS-1:0]      min_width_us;
        logic [WIDTH_BITS-1:0]      max_width_us;
        logic [WIDTH_BITS-1:0]      lead_us;
        logic [PULSE_BITS-1:0]      pulse_len_us;
        logic [WIDTH_BITS-1:0]      repeat_us;
    } cfg_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] width;
        logic                  in_window;
        logic [WIDTH_BITS-1:0] cross_delay;
    } width_res_t;

endpackage

### rtl/zcp_cfg_regs.sv
// Configuration register file and effective timestamp period.
module zcp_cfg_regs
    import zcp_pkg::*;
#(
    parameter int TIME_BITS = 20,
    parameter int CW        = 21
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    output cfg_t                      cfg,
    output logic [CW-1:0]             period
);

    localparam logic [CW-1:0] PERIOD_CAP = CW'(1) << TIME_BITS;
    localparam logic [CW-1:0] PERIOD_MIN = CW'(2);

    cfg_t          cfg_reg;
    logic [CW-1:0] wrap_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wrap_period_us <= RST_WRAP_PERIOD;
            cfg_reg.min_width_us   <= RST_MIN_WIDTH;
            cfg_reg.max_width_us   <= RST_MAX_WIDTH;
            cfg_reg.lead_us        <= RST_LEAD;
            cfg_reg.pulse_len_us   <= RST_PULSE_LEN;
            cfg_reg.repeat_us      <= RST_REPEAT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WRAP_PERIOD: cfg_reg.wrap_period_us <= cfg_wdata;
                REG_MIN_WIDTH:   cfg_reg.min_width_us   <= cfg_wdata[WIDTH_BITS-1:0];
                REG_MAX_WIDTH:   cfg_reg.max_width_us   <= cfg_wdata[WIDTH_BITS-1:0];
                REG_LEAD:        cfg_reg.lead_us        <= cfg_wdata[WIDTH_BITS-1:0];
                REG_PULSE_LEN:   cfg_reg.pulse_len_us   <= cfg_wdata[PULSE_BITS-1:0];
                REG_REPEAT:      cfg_reg.repeat_us      <= cfg_wdata[WIDTH_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp the modulus into [2, 2^TIME_BITS]
    always_comb
    begin
        wrap_x = CW'(cfg_reg.wrap_period_us);
        if (wrap_x < PERIOD_MIN)
            period = PERIOD_MIN;
        else if (wrap_x > PERIOD_CAP)
            period = PERIOD_CAP;
        else
            period = wrap_x;
    end

    assign cfg = cfg_reg;

endmodule

### rtl/zcp_width_calc.sv
// Low-phase width measurement, window check and cross delay.
module zcp_width_calc
    import zcp_pkg::*;
#(
    parameter int TIME_BITS = 20,
    parameter int CW        = 21
)
(
    input  logic [TIME_BITS-1:0] time_count,
    input  logic [TIME_BITS-1:0] fall_stamp,
    input  logic [CW-1:0]        period,
    input  cfg_t                 cfg,
    output width_res_t           res
);

    localparam int XW = CW + 1;

    logic [XW-1:0]         tc_x;
    logic [XW-1:0]         fs_x;
    logic [XW-1:0]         wrap_sum;
    logic [XW-1:0]         raw;
    logic [WIDTH_BITS-1:0] w;
    logic [WIDTH_BITS-1:0] half;

    always_comb
    begin
        tc_x     = XW'(time_count);
        fs_x     = XW'(fall_stamp);
        wrap_sum = XW'(period) + tc_x;
        // wrap arithmetic when the rise stamp is not above the fall stamp
        if (tc_x > fs_x)
            raw = tc_x - fs_x;
        else if (fs_x > wrap_sum)
            raw = '0;
        else
            raw = wrap_sum - fs_x;
        // saturate to the width field
        if (raw > XW'(WIDTH_MAX))
            w = WIDTH_MAX;
        else
            w = raw[WIDTH_BITS-1:0];
        half          = w >> 1;
        res.width     = w;
        res.in_window = (w >= cfg.min_width_us) && (w <= cfg.max_width_us);
        res.cross_delay = (half >= cfg.lead_us) ? (half - cfg.lead_us) : '0;
    end

endmodule

### rtl/zero_cross_pulse_generator.sv
// Top level: zero-cross pulse generator with stream ports and config write port.
// An accepted input beat enters the input register, then its state
// update enters the result register; tick state updates in a single pass.
// Throughput: one tick per clock unless m_tready stalls the output.
// Reset (rst_n, async low): timers idle, disarmed, level assumed high,
// timestamp 0, registers at their defaults, both stream stages empty.
module zero_cross_pulse_generator
    import zcp_pkg::*;
#(
    parameter int TIME_BITS = 20
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // slave side: tdata[0] = comparator_level, [7:1] zero
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,
    // master side: tdata[0] = pulse_out, [1] = fire, [2] = width_ready,
    // [22:3] = width_us, [23] = width_in_window
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    // comparison width wide enough for the 21-bit modulus and 2^TIME_BITS
    localparam int CW = (TIME_BITS + 1 > PERIOD_CFG_BITS) ? TIME_BITS + 1 : PERIOD_CFG_BITS;

    cfg_t          cfg;
    logic [CW-1:0] period;
    width_res_t    wres;

    // stream stage registers
    logic in_valid_reg;
    logic in_level_reg;
    logic m_valid_reg;
    logic [23:0] m_data_reg;
    logic [23:0] m_data_next;
    logic advance;

    // tick state
    logic [TIME_BITS-1:0]  time_count_reg, time_count_next;
    logic [TIME_BITS-1:0]  fall_stamp_reg, fall_stamp_next;
    logic                  prev_level_reg, prev_level_next;
    logic                  armed_reg, armed_next;
    logic [WIDTH_BITS-1:0] cross_delay_reg, cross_delay_next;
    logic [WIDTH_BITS-1:0] delay_left_reg, delay_left_next;
    logic                  delay_running_reg, delay_running_next;
    logic [PULSE_BITS-1:0] pulse_left_reg, pulse_left_next;
    logic [WIDTH_BITS-1:0] last_width_reg, last_width_next;
    logic                  last_in_window_reg, last_in_window_next;

    logic             fire;
    logic             ready;
    logic [TIME_BITS:0] tc_plus;

    zcp_cfg_regs #(
        .TIME_BITS (TIME_BITS),
        .CW        (CW)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .period    (period)
    );

    zcp_width_calc #(
        .TIME_BITS (TIME_BITS),
        .CW        (CW)
    ) u_width (
        .time_count (time_count_reg),
        .fall_stamp (fall_stamp_reg),
        .period     (period),
        .cfg        (cfg),
        .res        (wres)
    );

    // The result register frees when empty or when its beat is taken; the
    // input register frees when empty or when it moves forward.
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // One tick of the model: pulse countdown, delay countdown and fire,
    // then edge handling, then timestamp advance.
    always_comb
    begin
        time_count_next     = time_count_reg;
        fall_stamp_next     = fall_stamp_reg;
        armed_next          = armed_reg;
        cross_delay_next    = cross_delay_reg;
        delay_left_next     = delay_left_reg;
        delay_running_next  = delay_running_reg;
        last_width_next     = last_width_reg;
        last_in_window_next = last_in_window_reg;
        fire                = 1'b0;
        ready               = 1'b0;

        // pulse countdown
        pulse_left_next = (pulse_left_reg != '0) ? pulse_left_reg - 1'b1 : pulse_left_reg;

        // delay timer: expiry is handled before any edge of this tick
        if (delay_running_reg)
        begin
            if (delay_left_reg != '0)
                delay_left_next = delay_left_reg - 1'b1;
            if (delay_left_next == '0)
            begin
                fire            = 1'b1;
                pulse_left_next = cfg.pulse_len_us;
                if (armed_reg)
                begin
                    delay_left_next = cfg.repeat_us;
                    armed_next      = 1'b0;
                end
                else
                begin
                    delay_running_next = 1'b0;
                end
            end
        end

        // edges
        if (prev_level_reg && !in_level_reg)
        begin
            fall_stamp_next = time_count_reg;
            if (armed_next)
            begin
                delay_left_next    = cross_delay_reg;
                delay_running_next = 1'b1;
            end
        end
        else if (!prev_level_reg && in_level_reg)
        begin
            ready               = 1'b1;
            last_width_next     = wres.width;
            last_in_window_next = wres.in_window;
            if (wres.in_window)
            begin
                cross_delay_next = wres.cross_delay;
                armed_next       = 1'b1;
            end
        end
        prev_level_next = in_level_reg;

        // timestamp advance; a stamp at or past a lowered period wraps to 0
        tc_plus = {1'b0, time_count_reg} + 1'b1;
        if (CW'(tc_plus) >= period)
            time_count_next = '0;
        else
            time_count_next = tc_plus[TIME_BITS-1:0];

        m_data_next = {last_in_window_next, last_width_next, ready, fire,
                       (pulse_left_next != '0)};
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_level_reg <= s_tdata[0];
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (advance)
            m_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
            m_data_reg <= m_data_next;
    end

    // tick state: commit only when a tick moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_count_reg     <= '0;
            fall_stamp_reg     <= '0;
            prev_level_reg     <= 1'b1;
            armed_reg          <= 1'b0;
            cross_delay_reg    <= '0;
            delay_left_reg     <= '0;
            delay_running_reg  <= 1'b0;
            pulse_left_reg     <= '0;
            last_width_reg     <= '0;
            last_in_window_reg <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            time_count_reg     <= time_count_next;
            fall_stamp_reg     <= fall_stamp_next;
            prev_level_reg     <= prev_level_next;
            armed_reg          <= armed_next;
            cross_delay_reg    <= cross_delay_next;
            delay_left_reg     <= delay_left_next;
            delay_running_reg  <= delay_running_next;
            pulse_left_reg     <= pulse_left_next;
            last_width_reg     <= last_width_next;
            last_in_window_reg <= last_in_window_next;
        end
    end

endmodule
